// File: rtl/core/mlpa_pkg.sv
// Shared constants and types of the multichannel low-pass averager.
package mlpa_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int CH_W          = 2;
  localparam int VALUE_W       = 16;
  localparam int FACTOR_W      = 8;
  localparam int REG_COUNT     = 4;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd5;

  // factor * old + sample is held in 25 signed bits; its magnitude fits 24 bits
  localparam int ACC_W = VALUE_W + FACTOR_W + 1;
  localparam int MAG_W = ACC_W - 1;
  // divisor is factor + 1, from 1 to 256
  localparam int DIV_W = FACTOR_W + 1;

  // Divide request from the sequencer to the divider
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

// File: rtl/core/mlpa_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module mlpa_div (
  input  logic                      clk,
  input  logic                      rst,
  input  mlpa_pkg::div_req_t        req,
  output logic                      done,
  output logic [mlpa_pkg::MAG_W-1:0] quotient
);
  import mlpa_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] dvd;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] trial;

  // Shift in the next dividend bit and try the subtract
  assign shifted = {rem, dvd[MAG_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        // Keep the difference when it did not go negative, else restore
        if (!trial[DIV_W+1]) begin
          rem <= trial[DIV_W-1:0];
        end else begin
          rem <= shifted[DIV_W-1:0];
        end
        dvd <= {dvd[MAG_W-2:0], ~trial[DIV_W+1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

// File: rtl/core/multichannel_lowpass_averager_top.sv
// Per-channel exponential moving average with an iterative shared divider.
// Each sample steps through PROD (product, divider start), DIV (divider
// iterations until done) and FIN (write-back and output register load, held
// while the output register is full). A new sample is taken only in IDLE,
// after the previous one has been written back.
// Reset (rst, synchronous): filtered values cleared to zero, factors set to 5,
// output empty; no clearing pass.
module multichannel_lowpass_averager_top (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,  // [15:0] sample_value
  input  logic [7:0]                  s_tuser,  // [1:0] sample_channel
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,  // [15:0] filtered_value, [17:16] next_channel
  output logic [7:0]                  m_tuser,  // [1:0] out_channel
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mlpa_pkg::ADDR_W-1:0] paddr,
  input  logic [mlpa_pkg::DATA_W-1:0] pwdata,
  output logic [mlpa_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import mlpa_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    PROD,
    DIV,
    FIN
  } state_t;

  state_t                   state;
  logic [FACTOR_W-1:0]      factor [REG_COUNT];
  logic [VALUE_W-1:0]       store  [REG_COUNT];
  logic [CH_W-1:0]          ch;
  logic [VALUE_W-1:0]       sample;
  logic                     neg;
  logic [CH_W-1:0]          in_ch;
  logic [CH_W-1:0]          nxt_ch;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         acc_abs;
  logic [MAG_W-1:0]         quot;
  logic [MAG_W-1:0]         quot_signed;
  logic                     div_done;
  div_req_t                 req;
  logic [REG_COUNT-1:0]     cfg_sel;
  logic                     cfg_wr;

  // Reduce the channel tag modulo the channel count
  always_comb begin
    logic [CH_W:0] c;
    c = {1'b0, s_tuser[CH_W-1:0]};
    for (int i = 0; i < 3; i++) begin
      if (c >= (CH_W+1)'(CHANNEL_COUNT)) begin
        c = c - (CH_W+1)'(CHANNEL_COUNT);
      end
    end
    in_ch = c[CH_W-1:0];
  end

  // Next channel to convert, wrapping at the channel count
  always_comb begin
    logic [CH_W:0] n;
    n = {1'b0, ch} + 1'b1;
    if (n == (CH_W+1)'(CHANNEL_COUNT)) begin
      n = '0;
    end
    nxt_ch = n[CH_W-1:0];
  end

  // Form factor * old + sample and take its magnitude
  assign acc = $signed({1'b0, factor[ch]}) * $signed(store[ch])
             + ACC_W'($signed(sample));
  assign acc_abs = acc[ACC_W-1] ? (~acc + 1'b1) : acc;

  assign req.start    = (state == PROD);
  assign req.dividend = acc_abs[MAG_W-1:0];
  assign req.divisor  = {1'b0, factor[ch]} + 1'b1;

  mlpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .done     (div_done),
    .quotient (quot)
  );

  // Truncation toward zero: divide magnitudes, then restore the sign
  assign quot_signed = neg ? (~quot + 1'b1) : quot;

  assign s_tready = (state == IDLE);

  // Sequencer, filtered-value store and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        store[i] <= '0;
      end
    end else begin
      // Drop valid once taken, unless a new result lands in the same cycle
      if (m_tvalid && m_tready && state != FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            ch     <= in_ch;
            sample <= s_tdata;
            state  <= PROD;
          end
        end
        PROD: begin
          neg   <= acc[ACC_W-1];
          state <= DIV;
        end
        DIV: begin
          if (div_done) begin
            state <= FIN;
          end
        end
        FIN: begin
          // Hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            store[ch] <= quot_signed[VALUE_W-1:0];
            m_tvalid  <= 1'b1;
            m_tdata   <= {6'b0, nxt_ch, quot_signed[VALUE_W-1:0]};
            m_tuser   <= {6'b0, ch};
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_sel[i] = (paddr[ADDR_W-1:2] == (ADDR_W-2)'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        factor[i] <= FACTOR_RESET;
      end
    end else if (cfg_wr) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (cfg_sel[i]) begin
          factor[i] <= pwdata[FACTOR_W-1:0];
        end
      end
    end
  end

  assign prdata = {(DATA_W-FACTOR_W)'(0), factor[paddr[ADDR_W-1:2]]};

endmodule

// File: test/multichannel_lowpass_averager_top_tb.sv
// Self-checking testbench of the multichannel low-pass averager top level.
`timescale 1ns / 100ps

module multichannel_lowpass_averager_top_tb;
  import mlpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 144;

  // One expected filter update as it leaves the block
  typedef struct {
    logic [CH_W-1:0]    channel;
    logic [VALUE_W-1:0] value;
    logic [CH_W-1:0]    next;
  } avg_result_t;

  // Per-channel moving average predictor and the queue of pending updates
  class averager_scoreboard;
    logic [FACTOR_W-1:0]       factor [REG_COUNT];
    logic signed [VALUE_W-1:0] smoothed [CHANNEL_COUNT];
    avg_result_t               pending_updates [$];
    int                        errors;

    function new();
      for (int i = 0; i < REG_COUNT; i++) factor[i] = FACTOR_RESET;
      for (int i = 0; i < CHANNEL_COUNT; i++) smoothed[i] = '0;
      errors = 0;
    endfunction

    function void set_factor(int idx, logic [DATA_W-1:0] wdata);
      if (idx < REG_COUNT) factor[idx] = wdata[FACTOR_W-1:0];
    endfunction

    // Advance the channel's average for an accepted sample
    function void note_sample(logic [CH_W-1:0] ch, logic signed [VALUE_W-1:0] sample);
      int          c;
      longint      acc;
      longint      quo;
      avg_result_t upd;
      c   = int'(ch) % CHANNEL_COUNT;
      acc = longint'(factor[c]) * longint'(smoothed[c]) + longint'(sample);
      quo = acc / (longint'(factor[c]) + 1);
      if (quo > 32767) quo = 32767;
      else if (quo < -32768) quo = -32768;
      smoothed[c] = quo[VALUE_W-1:0];
      upd.channel = c[CH_W-1:0];
      upd.value   = quo[VALUE_W-1:0];
      upd.next    = CH_W'((c + 1) % CHANNEL_COUNT);
      pending_updates.push_back(upd);
    endfunction

    // Compare one output transfer with the oldest pending update
    function void check_result(logic [23:0] tdata, logic [7:0] tuser);
      avg_result_t exp_r;
      if (pending_updates.size() == 0) begin
        $error("unexpected result: out_channel %0d filtered_value %0d",
               tuser[CH_W-1:0], $signed(tdata[VALUE_W-1:0]));
        errors++;
        return;
      end
      exp_r = pending_updates.pop_front();
      if (tuser[CH_W-1:0] !== exp_r.channel) begin
        $error("out_channel: expected %0d, actual %0d", exp_r.channel, tuser[CH_W-1:0]);
        errors++;
      end
      if (tdata[VALUE_W-1:0] !== exp_r.value) begin
        $error("filtered_value: expected %0d, actual %0d",
               $signed(exp_r.value), $signed(tdata[VALUE_W-1:0]));
        errors++;
      end
      if (tdata[VALUE_W+CH_W-1:VALUE_W] !== exp_r.next) begin
        $error("next_channel: expected %0d, actual %0d",
               exp_r.next, tdata[VALUE_W+CH_W-1:VALUE_W]);
        errors++;
      end
    endfunction

    function int pending();
      return pending_updates.size();
    endfunction
  endclass

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata  = '0;
  logic [7:0]          s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [23:0]         m_tdata;
  logic [7:0]          m_tuser;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ADDR_W-1:0]   paddr    = '0;
  logic [DATA_W-1:0]   pwdata   = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  averager_scoreboard  sb = new();
  int                  src_idle_pct   = 0;
  int                  sink_stall_pct = 0;
  bit                  hold_req       = 1'b0;
  int                  hold_left      = 0;
  int                  idle_cycles    = 0;

  multichannel_lowpass_averager_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sink: check each output transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one sample, with random idle cycles ahead of it, until it is taken
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= {6'b0, ch};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(ch, val);
  endtask

  // Write one factor register; upper data bits carry noise
  task automatic write_factor(input int idx, input logic [FACTOR_W-1:0] f);
    logic [DATA_W-1:0] wdata;
    wdata = $urandom();
    wdata[FACTOR_W-1:0] = f;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_factor(idx, wdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read one factor register back and compare its low byte
  task automatic read_factor(input int idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(4 * idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[FACTOR_W-1:0] !== sb.factor[idx]) begin
      $error("factor_ch%0d: expected %0d, actual %0d", idx, sb.factor[idx],
             prdata[FACTOR_W-1:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait until every pending update has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CH_W-1:0]     ch;
    logic [VALUE_W-1:0]  val;
    logic [FACTOR_W-1:0] f;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset factors, full-scale and near-zero samples on every channel
    for (int i = 0; i < REG_COUNT; i++) read_factor(i);
    send_sample(2'd0, 16'h7FFF);
    send_sample(2'd1, 16'h8000);
    send_sample(2'd2, 16'h0000);
    send_sample(2'd3, 16'hFFFF);
    send_sample(2'd0, 16'h0001);
    send_sample(2'd0, 16'h8000);
    send_sample(2'd1, 16'h7FFF);
    wait_drained();

    // Factor zero, factor one (truncation toward zero), widest factors
    write_factor(0, 8'd0);
    write_factor(1, 8'd255);
    write_factor(2, 8'd1);
    write_factor(3, 8'd128);
    for (int i = 0; i < REG_COUNT; i++) read_factor(i);
    send_sample(2'd0, 16'h7FFF);
    send_sample(2'd0, 16'h8000);
    send_sample(2'd1, 16'h7FFF);
    send_sample(2'd1, 16'h8000);
    send_sample(2'd2, 16'hFFFF);
    send_sample(2'd2, 16'h0000);
    send_sample(2'd2, 16'hFFFD);
    send_sample(2'd3, 16'h3039);
    wait_drained();

    // Saturated history with the heaviest weight
    write_factor(1, 8'd0);
    send_sample(2'd1, 16'h7FFF);
    wait_drained();
    write_factor(0, 8'd255);
    write_factor(1, 8'd255);
    read_factor(0);
    read_factor(1);
    send_sample(2'd1, 16'h7FFF);
    send_sample(2'd0, 16'h8000);
    send_sample(2'd0, 16'h8000);
    send_sample(2'd3, 16'h8000);
    send_sample(2'd2, 16'h7FFF);
    wait_drained();

    // Random phases over factor settings and idling modes
    ch = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (p == 0) f = 8'd0;
        else if (p == 1) f = 8'd255;
        else if ($urandom_range(3) == 0) f = ($urandom_range(1) == 0) ? 8'd1 : 8'd254;
        else f = FACTOR_W'($urandom_range(255));
        write_factor(i, f);
        read_factor(i);
      end
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 73; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 73; end
        default: begin src_idle_pct = 27; sink_stall_pct = 27; end
      endcase
      // Long sink hold while the source keeps offering
      if (p == 4) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(3))
          0, 1: ch = CH_W'((int'(ch) + 1) % CHANNEL_COUNT);
          2: ch = ch;
          default: ch = CH_W'($urandom_range(CHANNEL_COUNT - 1));
        endcase
        case ($urandom_range(7))
          0: val = 16'h7FFF;
          1: val = 16'h8000;
          2: val = VALUE_W'($urandom_range(2)) - 16'd1;
          default: val = VALUE_W'($urandom());
        endcase
        send_sample(ch, val);
      end
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: multichannel_lowpass_averager_top.f
rtl/core/mlpa_pkg.sv
rtl/core/mlpa_div.sv
rtl/core/multichannel_lowpass_averager_top.sv
test/multichannel_lowpass_averager_top_tb.sv
